>>> design/cantp_pkg.sv
// shared types and constants of the can transport receive reassembler
package cantp_pkg;

    typedef enum logic [1:0]
    {
        KIND_PAYLOAD = 2'd0,
        KIND_STATUS  = 2'd1,
        KIND_FC      = 2'd2
    } kind_t;

    localparam logic [2:0] ST_PROGRESS    = 3'd0;
    localparam logic [2:0] ST_ID_MISMATCH = 3'd1;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
    localparam logic [2:0] ST_SEQ_MISMATCH = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd4;
    localparam logic [2:0] ST_SUCCESS     = 3'd5;
    localparam logic [2:0] ST_TIMEOUT     = 3'd6;

    localparam logic [3:0] FT_SINGLE  = 4'd0;
    localparam logic [3:0] FT_FIRST   = 4'd1;
    localparam logic [3:0] FT_CONSEC  = 4'd2;
    localparam logic [3:0] FT_FLOW    = 4'd3;

    localparam logic [2:0] CFG_RECEIVE_ID = 3'd0;
    localparam logic [2:0] CFG_TRANSMIT_ID = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT_MS = 3'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [3:0]  DLC_MAX       = 4'd8;
    localparam logic [11:0] FF_MIN_LEN    = 12'd8;
    localparam logic [2:0]  FF_BYTES      = 3'd6;

    typedef struct packed
    {
        logic [2:0]       nbytes;
        logic [7:0][7:0]  data;
        logic [11:0]      base_off;
        logic             fc;
        logic [10:0]      fc_id;
        logic [2:0]       status;
        logic [11:0]      len_out;
    } job_t;

endpackage

>>> design/cantp_front.sv
// front end: frame classification, reception state and config registers
module cantp_front
    import cantp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] now_ms,
    input  logic [10:0] can_id,
    input  logic [3:0]  dlc,
    input  logic [7:0]  frame_byte0,
    input  logic [7:0]  frame_byte1,
    input  logic [7:0]  frame_byte2,
    input  logic [7:0]  frame_byte3,
    input  logic [7:0]  frame_byte4,
    input  logic [7:0]  frame_byte5,
    input  logic [7:0]  frame_byte6,
    input  logic [7:0]  frame_byte7,
    input  logic        job_full,
    output logic        job_push,
    output job_t        job
);

    logic [10:0] receive_id_reg;
    logic [10:0] transmit_id_reg;
    logic [15:0] timeout_ms_reg;

    logic        receiving_reg, receiving_next;
    logic [3:0]  exp_seq_reg, exp_seq_next;
    logic [11:0] total_len_reg, total_len_next;
    logic [11:0] bytes_rx_reg, bytes_rx_next;
    logic [31:0] last_time_reg, last_time_next;

    logic [3:0]  dlc_c;
    logic [3:0]  ftype;
    logic [3:0]  nib;
    logic [11:0] ff_len;
    logic [31:0] gap;
    logic [11:0] rem;
    logic [11:0] cf_cnt;
    logic [11:0] br_sum;
    logic [3:0]  dlc_m1;

    assign in_stall = job_full;
    assign job_push = in_valid && !job_full;

    always_comb
    begin
        dlc_c  = (dlc > DLC_MAX) ? DLC_MAX : dlc;
        dlc_m1 = dlc_c - 4'd1;
        ftype  = frame_byte0[7:4];
        nib    = frame_byte0[3:0];
        ff_len = {nib, frame_byte1};
        gap    = now_ms - last_time_reg;
        rem    = (bytes_rx_reg > total_len_reg) ? 12'd0 : (total_len_reg - bytes_rx_reg);
        cf_cnt = ({8'd0, dlc_m1} > rem) ? rem : {8'd0, dlc_m1};
        br_sum = bytes_rx_reg + cf_cnt;

        receiving_next = receiving_reg;
        exp_seq_next   = exp_seq_reg;
        total_len_next = total_len_reg;
        bytes_rx_next  = bytes_rx_reg;
        last_time_next = last_time_reg;

        job.nbytes   = 3'd0;
        job.data     = {8'h00, frame_byte7, frame_byte6, frame_byte5, frame_byte4,
                        frame_byte3, frame_byte2, frame_byte1};
        job.base_off = 12'd0;
        job.fc       = 1'b0;
        job.fc_id    = transmit_id_reg;
        job.status   = ST_PROGRESS;
        job.len_out  = 12'd0;

        if (command)
        begin
            if (receiving_reg && (gap > {16'd0, timeout_ms_reg}))
            begin
                receiving_next = 1'b0;
                job.status     = ST_TIMEOUT;
            end
        end
        else if (can_id != receive_id_reg)
        begin
            job.status = ST_ID_MISMATCH;
        end
        else if (dlc_c == 4'd0)
        begin
            receiving_next = 1'b0;
            job.status     = ST_BAD_TYPE;
        end
        else
        begin
            case (ftype)
                FT_SINGLE:
                begin
                    if (nib != dlc_m1)
                    begin
                        job.status = ST_LEN_MISMATCH;
                    end
                    else
                    begin
                        job.nbytes     = nib[2:0];
                        receiving_next = 1'b0;
                        exp_seq_next   = 4'd0;
                        job.status     = ST_SUCCESS;
                        job.len_out    = {8'd0, nib};
                    end
                end
                FT_FIRST:
                begin
                    if ((dlc_c != DLC_MAX) || (ff_len < FF_MIN_LEN))
                    begin
                        job.status = ST_LEN_MISMATCH;
                    end
                    else
                    begin
                        job.nbytes     = FF_BYTES;
                        job.data       = {16'h0000, frame_byte7, frame_byte6, frame_byte5,
                                          frame_byte4, frame_byte3, frame_byte2};
                        job.fc         = 1'b1;
                        receiving_next = 1'b1;
                        exp_seq_next   = 4'd1;
                        total_len_next = ff_len;
                        bytes_rx_next  = {9'd0, FF_BYTES};
                        last_time_next = now_ms;
                    end
                end
                FT_CONSEC:
                begin
                    if (!receiving_reg)
                    begin
                        job.status = ST_SEQ_MISMATCH;
                    end
                    else if (nib != exp_seq_reg)
                    begin
                        receiving_next = 1'b0;
                        job.status     = ST_SEQ_MISMATCH;
                    end
                    else
                    begin
                        job.nbytes     = cf_cnt[2:0];
                        job.base_off   = bytes_rx_reg;
                        bytes_rx_next  = br_sum;
                        exp_seq_next   = nib + 4'd1;
                        last_time_next = now_ms;
                        if (br_sum >= total_len_reg)
                        begin
                            receiving_next = 1'b0;
                            job.status     = ST_SUCCESS;
                            job.len_out    = total_len_reg;
                        end
                    end
                end
                FT_FLOW:
                begin
                    job.status = ST_PROGRESS;
                end
                default:
                begin
                    receiving_next = 1'b0;
                    job.status     = ST_BAD_TYPE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_id_reg  <= 11'd0;
            transmit_id_reg <= 11'd0;
            timeout_ms_reg  <= TIMEOUT_RESET;
            receiving_reg   <= 1'b0;
            exp_seq_reg     <= 4'd0;
            total_len_reg   <= 12'd0;
            bytes_rx_reg    <= 12'd0;
            last_time_reg   <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RECEIVE_ID:  receive_id_reg  <= cfg_wdata[10:0];
                    CFG_TRANSMIT_ID: transmit_id_reg <= cfg_wdata[10:0];
                    CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (job_push)
            begin
                receiving_reg <= receiving_next;
                exp_seq_reg   <= exp_seq_next;
                total_len_reg <= total_len_next;
                bytes_rx_reg  <= bytes_rx_next;
                last_time_reg <= last_time_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_rx_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> (bytes_rx_reg < total_len_reg))
        else $error("reception running with all bytes already received");

    a_rx_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> (total_len_reg >= FF_MIN_LEN))
        else $error("reception running with a short message length");
`endif

endmodule

>>> design/cantp_fifo.sv
// small register queue between front and back
module cantp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/cantp_back.sv
// back end: sequences each job into payload, flow-control and status results
module cantp_back
    import cantp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  job_t        head,
    output logic        job_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [11:0] byte_offset,
    output logic [11:0] message_length,
    output logic [2:0]  status,
    output logic [10:0] fc_target_id,
    output logic        last
);

    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [11:0] offset_reg, offset_next;
    logic [11:0] length_reg, length_next;
    logic [2:0]  status_reg, status_next;
    logic [10:0] fc_id_reg, fc_id_next;
    logic        last_reg, last_next;
    logic [2:0]  pos_reg;

    logic        load;
    logic [3:0]  n_total;

    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign job_pop = load && last_next;
    assign n_total = {1'b0, head.nbytes} + {3'd0, head.fc} + 4'd1;

    always_comb
    begin
        kind_next   = KIND_STATUS;
        byte_next   = 8'd0;
        offset_next = 12'd0;
        length_next = 12'd0;
        status_next = 3'd0;
        fc_id_next  = 11'd0;
        last_next   = ({1'b0, pos_reg} == (n_total - 4'd1));
        if (pos_reg < head.nbytes)
        begin
            kind_next   = KIND_PAYLOAD;
            byte_next   = head.data[pos_reg];
            offset_next = head.base_off + {9'd0, pos_reg};
        end
        else if (head.fc && (pos_reg == head.nbytes))
        begin
            kind_next  = KIND_FC;
            fc_id_next = head.fc_id;
        end
        else
        begin
            status_next = head.status;
            length_next = head.len_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last_next ? 3'd0 : pos_reg + 3'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            byte_reg   <= byte_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            status_reg <= status_next;
            fc_id_reg  <= fc_id_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign payload_byte   = byte_reg;
    assign byte_offset    = offset_reg;
    assign message_length = length_reg;
    assign status         = status_reg;
    assign fc_target_id   = fc_id_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (kind_reg == KIND_STATUS))
        else $error("final transfer of a frame is not a status report");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_STATUS)) |-> last_reg)
        else $error("status report not marked last");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 3'd0) |-> head_valid)
        else $error("job left the queue before its status went out");
`endif

endmodule

>>> design/can_transport_receive_reassembler_top.sv
// top level of the can transport receive reassembler
// the first result of a frame or tick transfer passes the job queue, then the output register
// each item yields 1 to 8 results, one per cycle from the back-end sequencer while out_stall is low
// a frame yields its payload bytes, then a flow-control request if any, then a status report
// the front takes a new item every cycle while the job queue has room
// reset clears reception state and queue, config to 0, 0, 1000 ms
module can_transport_receive_reassembler_top
    import cantp_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] now_ms,
    input  logic [10:0] can_id,
    input  logic [3:0]  dlc,
    input  logic [7:0]  frame_byte0,
    input  logic [7:0]  frame_byte1,
    input  logic [7:0]  frame_byte2,
    input  logic [7:0]  frame_byte3,
    input  logic [7:0]  frame_byte4,
    input  logic [7:0]  frame_byte5,
    input  logic [7:0]  frame_byte6,
    input  logic [7:0]  frame_byte7,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [11:0] byte_offset,
    output logic [11:0] message_length,
    output logic [2:0]  status,
    output logic [10:0] fc_target_id,
    output logic        last
);

    job_t job_in;
    job_t job_head;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic head_valid;

    cantp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .now_ms      (now_ms),
        .can_id      (can_id),
        .dlc         (dlc),
        .frame_byte0 (frame_byte0),
        .frame_byte1 (frame_byte1),
        .frame_byte2 (frame_byte2),
        .frame_byte3 (frame_byte3),
        .frame_byte4 (frame_byte4),
        .frame_byte5 (frame_byte5),
        .frame_byte6 (frame_byte6),
        .frame_byte7 (frame_byte7),
        .job_full    (job_full),
        .job_push    (job_push),
        .job         (job_in)
    );

    cantp_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (job_in),
        .full       (job_full),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head_data  (job_head)
    );

    cantp_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (job_head),
        .job_pop        (job_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .byte_offset    (byte_offset),
        .message_length (message_length),
        .status         (status),
        .fc_target_id   (fc_target_id),
        .last           (last)
    );

endmodule
